FILE: sv/mr16_pkg.sv
package mr16_pkg;

  // One request: a command with its instruction word and direct-access operands.
  typedef struct packed {
    logic [2:0]         cmd;
    logic [15:0]        instr;
    logic               slot_loaded;
    logic [7:0]         index;
    logic signed [31:0] value;
  } req_t;

  // One result: program counter after the request, status and read word.
  typedef struct packed {
    logic [11:0]        pc_out;
    logic [1:0]         status;
    logic signed [31:0] read_data;
  } res_t;

  // Commands.
  localparam logic [2:0] CMD_EXEC   = 3'd0;
  localparam logic [2:0] CMD_REG_WR = 3'd1;
  localparam logic [2:0] CMD_MEM_WR = 3'd2;
  localparam logic [2:0] CMD_REG_RD = 3'd3;
  localparam logic [2:0] CMD_MEM_RD = 3'd4;

  // Opcodes.
  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_J     = 4'd2;
  localparam logic [3:0] OP_ADDI  = 4'd4;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_LW    = 4'd11;
  localparam logic [3:0] OP_SW    = 4'd15;

  // R-type function codes; anything else adds.
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADOP = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Result queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

endpackage

FILE: sv/mr16_result_fifo.sv
module mr16_result_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  mr16_pkg::res_t             push_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output mr16_pkg::res_t             res,
  output logic [mr16_pkg::QCNT_W-1:0] count
);
  import mr16_pkg::*;

  res_t              entries [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              pop;

  // The producer reserves room before it starts a request, so a push always fits.
  assign pop       = res_valid & res_ready;
  assign res_valid = (count != '0);
  assign res       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

FILE: sv/mini_risc16_execute_unit.sv
// Each result is queued as its request leaves stage two. Throughput: one request per cycle
// while req_ready is high; operands come from the register file memory with forwarding
// from the two requests ahead, including a load's data straight off the data port.
// A four-entry result queue lets requests keep flowing while a result waits to be taken.
// Reset: synchronous; registers read as zero, pc is zero, and the data memory is cleared
// by a pass that writes zero to every word, during which no request is accepted.
module mini_risc16_execute_unit #(
  parameter int DATA_WORDS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mr16_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output mr16_pkg::res_t res
);
  import mr16_pkg::*;

  localparam int              AW        = $clog2(DATA_WORDS);
  localparam logic [31:0]     DW32      = 32'(DATA_WORDS);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(DATA_WORDS - 1);

  // ---------------------------------------------------------------------------
  // Acceptance. Room is reserved in the result queue for every request in
  // flight, so the pipeline itself never stalls.
  // ---------------------------------------------------------------------------
  logic              accept;
  logic              clearing;
  logic [AW-1:0]     clr_addr;
  logic [QCNT_W-1:0] q_count;
  logic [3:0]        occ;
  logic              v1;
  logic              v2;

  assign occ       = 4'(q_count) + 4'(v1) + 4'(v2);
  assign req_ready = !clearing && (occ < 4'(QUEUE_DEPTH));
  assign accept    = req_valid & req_ready;

  // ---------------------------------------------------------------------------
  // Register file: eight words in a two-read, one-write memory with registered
  // read data. A valid bit per entry makes an entry never written read as zero.
  // ---------------------------------------------------------------------------
  logic [31:0] rf_mem [0:7];
  logic [7:0]  rf_valid;
  logic [2:0]  rf_ra;
  logic [2:0]  rf_rb;
  logic [31:0] rf_qa;
  logic [31:0] rf_qb;
  logic        rf_va;
  logic        rf_vb;
  logic        rf_we;
  logic [2:0]  rf_wa;
  logic [31:0] rf_wd;

  // A register read request uses port A with its index in place of rs.
  assign rf_ra = (req.cmd == CMD_REG_RD) ? req.index[2:0] : req.instr[11:9];
  assign rf_rb = req.instr[8:6];

  always_ff @(posedge clk) begin
    rf_qa <= rf_mem[rf_ra];
    rf_qb <= rf_mem[rf_rb];
    rf_va <= rf_valid[rf_ra];
    rf_vb <= rf_valid[rf_rb];
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[rf_wa] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one: the accepted request with its operands.
  // ---------------------------------------------------------------------------
  req_t p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1 <= req;
    end
  end

  // Stage two and the last register write, kept for forwarding.
  logic [11:0] pc2;
  logic [1:0]  st2;
  logic [31:0] rd2;
  logic        mrd2;
  logic        we2;
  logic [2:0]  wa2;
  logic [31:0] wd2;
  logic        ld2;
  logic [31:0] s2_wd;
  logic        wbv;
  logic [2:0]  wba;
  logic [31:0] wbd;
  logic [31:0] dm_q;

  // A load's register value is the data memory word that arrives in stage two.
  assign s2_wd = ld2 ? dm_q : wd2;

  logic [11:0] pc;
  logic [3:0]  op;
  logic [2:0]  ra1;
  logic [2:0]  rb1;
  logic [2:0]  rt1;
  logic [2:0]  rd1;
  logic [2:0]  fn1;
  logic [31:0] imm32;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [31:0] ea;
  logic        ea_ok;
  logic [31:0] idx32;
  logic        idx_dm_ok;
  logic        idx_rf_ok;
  logic [11:0] pc_inc;
  logic [11:0] pc_next;
  logic [1:0]  st;
  logic        we;
  logic [2:0]  wa;
  logic [31:0] wd;
  logic        ld;
  logic        mrd;
  logic [31:0] rdata;
  logic        dm_we;
  logic [AW-1:0] dm_wa;
  logic [31:0] dm_wd;
  logic [AW-1:0] dm_ra;

  assign op    = p1.instr[15:12];
  assign ra1   = (p1.cmd == CMD_REG_RD) ? p1.index[2:0] : p1.instr[11:9];
  assign rb1   = p1.instr[8:6];
  assign rt1   = p1.instr[8:6];
  assign rd1   = p1.instr[5:3];
  assign fn1   = p1.instr[2:0];
  assign imm32 = {{26{p1.instr[5]}}, p1.instr[5:0]};

  // The request just ahead writes at the end of this cycle; the one before it
  // wrote at the same edge as our read, which returned the old word.
  always_comb begin
    if (v2 && we2 && (wa2 == ra1)) begin
      opa = s2_wd;
    end else if (wbv && (wba == ra1)) begin
      opa = wbd;
    end else begin
      opa = rf_va ? rf_qa : 32'd0;
    end
    if (v2 && we2 && (wa2 == rb1)) begin
      opb = s2_wd;
    end else if (wbv && (wba == rb1)) begin
      opb = wbd;
    end else begin
      opb = rf_vb ? rf_qb : 32'd0;
    end
  end

  assign ea        = opa + imm32;
  assign ea_ok     = !ea[31] && (ea < DW32);
  assign idx32     = {24'd0, p1.index};
  assign idx_dm_ok = (idx32 < DW32);
  assign idx_rf_ok = (p1.index[7:3] == 5'd0);
  assign pc_inc    = pc + 12'd1;

  // Execute and direct-access decode.
  always_comb begin
    pc_next = pc;
    st      = ST_OK;
    we      = 1'b0;
    wa      = rt1;
    wd      = ea;
    ld      = 1'b0;
    mrd     = 1'b0;
    rdata   = 32'd0;
    dm_we   = 1'b0;
    dm_wa   = idx32[AW-1:0];
    dm_wd   = $unsigned(p1.value);
    dm_ra   = (p1.cmd == CMD_EXEC) ? ea[AW-1:0] : idx32[AW-1:0];
    unique case (p1.cmd)
      CMD_EXEC: begin
        pc_next = pc_inc;
        if (!p1.slot_loaded) begin
          st = ST_EMPTY;
        end else begin
          unique case (op)
            OP_RTYPE: begin
              we = 1'b1;
              wa = rd1;
              case (fn1)
                FN_SUB:  wd = opa - opb;
                FN_AND:  wd = opa & opb;
                FN_OR:   wd = opa | opb;
                default: wd = opa + opb;
              endcase
            end
            OP_ADDI: begin
              we = 1'b1;
            end
            OP_LW: begin
              if (ea_ok) begin
                we = 1'b1;
                ld = 1'b1;
              end else begin
                st = ST_RANGE;
              end
            end
            OP_SW: begin
              if (ea_ok) begin
                dm_we = 1'b1;
                dm_wa = ea[AW-1:0];
                dm_wd = opb;
              end else begin
                st = ST_RANGE;
              end
            end
            OP_BEQ: begin
              if (opa == opb) begin
                pc_next = pc + imm32[11:0];
              end
            end
            OP_J: begin
              pc_next = p1.instr[11:0];
            end
            default: begin
              st = ST_BADOP;
            end
          endcase
        end
      end
      CMD_REG_WR: begin
        if (idx_rf_ok) begin
          we = 1'b1;
          wa = p1.index[2:0];
          wd = $unsigned(p1.value);
        end else begin
          st = ST_RANGE;
        end
      end
      CMD_MEM_WR: begin
        if (idx_dm_ok) begin
          dm_we = 1'b1;
        end else begin
          st = ST_RANGE;
        end
      end
      CMD_REG_RD: begin
        if (idx_rf_ok) begin
          rdata = opa;
        end else begin
          st = ST_RANGE;
        end
      end
      CMD_MEM_RD: begin
        if (idx_dm_ok) begin
          mrd = 1'b1;
        end else begin
          st = ST_RANGE;
        end
      end
      default: begin
        st = ST_BADOP;
      end
    endcase
  end

  // The program counter is updated in stage one, where the next request reads it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 12'd0;
    end else if (v1) begin
      pc <= pc_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Data memory: one write port and one registered read port. Stores and
  // direct writes land at the end of stage one, loads read at the same edge,
  // so a later request always sees an earlier store.
  // ---------------------------------------------------------------------------
  logic [31:0]   dm_mem [0:DATA_WORDS-1];
  logic          dm_wr_en;
  logic [AW-1:0] dm_wr_addr;
  logic [31:0]   dm_wr_data;

  assign dm_wr_en   = clearing | (v1 & dm_we);
  assign dm_wr_addr = clearing ? clr_addr : dm_wa;
  assign dm_wr_data = clearing ? 32'd0 : dm_wd;

  always_ff @(posedge clk) begin
    dm_q <= dm_mem[dm_ra];
    if (dm_wr_en) begin
      dm_mem[dm_wr_addr] <= dm_wr_data;
    end
  end

  // Clearing pass after reset, one word a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage two: loads complete, registers are written, the result is queued.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v2  <= 1'b0;
      wbv <= 1'b0;
    end else begin
      v2  <= v1;
      wbv <= v2 & we2;
    end
  end

  always_ff @(posedge clk) begin
    pc2  <= pc_next;
    st2  <= st;
    rd2  <= rdata;
    mrd2 <= mrd;
    we2  <= we;
    wa2  <= wa;
    wd2  <= wd;
    ld2  <= ld;
    wba  <= wa2;
    wbd  <= s2_wd;
  end

  assign rf_we = v2 & we2;
  assign rf_wa = wa2;
  assign rf_wd = s2_wd;

  res_t push_data;

  always_comb begin
    push_data.pc_out    = pc2;
    push_data.status    = st2;
    push_data.read_data = mrd2 ? $signed(dm_q) : $signed(rd2);
  end

  mr16_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (v2),
    .push_data (push_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .count     (q_count)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_room_reserved: assert property (@(posedge clk) disable iff (rst)
    occ <= 4'(QUEUE_DEPTH))
    else $error("requests in flight exceed the result queue");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!v1 && !v2))
    else $error("request in flight during the clearing pass");

  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("stage two holds a request that never passed stage one");

  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    !(v1 && (p1.cmd == CMD_EXEC)) |=> (pc == $past(pc)))
    else $error("program counter moved without an execute request");

endmodule
